FILE: rtl/btr_pkg.sv
package btr_pkg;

    // Font geometry and limits
    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_HEIGHT = 16;
    localparam int GLYPH_COUNT  = 256;
    localparam int MAX_ZOOM     = 4;
    localparam int FONT_DEPTH   = 4096;
    localparam int FONT_AW      = $clog2(FONT_DEPTH);
    localparam int ROW_W        = $clog2(GLYPH_HEIGHT);
    localparam int ZOOM_W       = 3;
    localparam int MASK_W       = 32;
    localparam int COORD_W      = 16;
    localparam int COLOR_W      = 32;
    localparam int CFG_IDX_W    = 1;

    // Input modes
    localparam logic [1:0] MODE_PUT  = 2'd0;
    localparam logic [1:0] MODE_SET  = 2'd1;
    localparam logic [1:0] MODE_LOAD = 2'd2;

    // Control characters
    localparam logic [7:0] CODE_CR = 8'd13;
    localparam logic [7:0] CODE_LF = 8'd10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COLOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM        = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // take the item on the input channel
        logic issue;    // read the current glyph row
    } btr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_glyph;   // input item draws a character
        logic last_row;   // current row is the final one of the character
        logic slot_free;  // read stage can take a new row
    } btr_sts_t;

    // Stretch one font byte horizontally by the zoom factor
    function automatic logic [MASK_W-1:0] scale_mask(input logic [7:0] bits,
                                                     input logic [ZOOM_W-1:0] z);
        logic [MASK_W-1:0] mask;
        mask = '0;
        unique case (z)
            3'd2:
                for (int j = 0; j < GLYPH_WIDTH * 2; j++) mask[j] = bits[j / 2];
            3'd3:
                for (int j = 0; j < GLYPH_WIDTH * 3; j++) mask[j] = bits[j / 3];
            3'd4:
                for (int j = 0; j < GLYPH_WIDTH * 4; j++) mask[j] = bits[j / 4];
            default:
                for (int j = 0; j < GLYPH_WIDTH; j++) mask[j] = bits[j];
        endcase
        return mask;
    endfunction

endpackage

FILE: rtl/bitmap_text_renderer.sv
// Bitmap text renderer: one font row read per cycle, one framebuffer row write per cycle,
// while the output does not stall. A character transfer passes through the render state,
// the font read stage and the output register, giving GLYPH_HEIGHT*zoom rows back to back
// when not stalled; the next item is taken only after the last row is read. Other items
// do not stall the input. Reset clears the cursor and output control, sets pixel_color to
// all ones and zoom to 1; the font store is undefined until loaded.
module bitmap_text_renderer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          mode,
    input  logic [7:0]                          char_code,
    input  logic [btr_pkg::COORD_W-1:0]         new_x,
    input  logic [btr_pkg::COORD_W-1:0]         new_y,
    input  logic [btr_pkg::FONT_AW-1:0]         font_address,
    input  logic [7:0]                          font_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [btr_pkg::COORD_W-1:0]         row_x,
    output logic [btr_pkg::COORD_W-1:0]         row_y,
    output logic [btr_pkg::MASK_W-1:0]          row_mask,
    output logic [btr_pkg::COLOR_W-1:0]         row_color,
    output logic                                last_row,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [btr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [btr_pkg::COLOR_W-1:0]         cfg_data
);

    import btr_pkg::*;

    btr_cmd_t cmd;
    btr_sts_t sts;
    logic     cfg_we;

    // Register writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    btr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    btr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .char_code    (char_code),
        .new_x        (new_x),
        .new_y        (new_y),
        .font_address (font_address),
        .font_byte    (font_byte),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .row_x        (row_x),
        .row_y        (row_y),
        .row_mask     (row_mask),
        .row_color    (row_color),
        .last_row     (last_row)
    );

endmodule

FILE: rtl/btr_ram.sv
module btr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, hold when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/btr_ctrl.sv
module btr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output btr_pkg::btr_cmd_t cmd,
    input  btr_pkg::btr_sts_t sts
);

    import btr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_RENDER = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // Decode commands
    always_comb
    begin
        cmd.accept = (state_reg == ST_IDLE) && in_valid;
        cmd.issue  = (state_reg == ST_RENDER) && sts.slot_free;
    end

    assign in_stall = (state_reg != ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept && sts.is_glyph)
                begin
                    state_next = ST_RENDER;
                end
            end
            ST_RENDER:
            begin
                if (cmd.issue && sts.last_row)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_issue_only_render: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (state_reg == ST_RENDER))
        else $error("row read outside render");

    a_glyph_starts_render: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && sts.is_glyph) |=> (state_reg == ST_RENDER))
        else $error("character transfer did not start render");

    a_no_accept_while_render: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RENDER) |-> !cmd.accept)
        else $error("input transfer during render");

endmodule

FILE: rtl/btr_datapath.sv
module btr_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  btr_pkg::btr_cmd_t                   cmd,
    output btr_pkg::btr_sts_t                   sts,
    input  logic [1:0]                          mode,
    input  logic [7:0]                          char_code,
    input  logic [btr_pkg::COORD_W-1:0]         new_x,
    input  logic [btr_pkg::COORD_W-1:0]         new_y,
    input  logic [btr_pkg::FONT_AW-1:0]         font_address,
    input  logic [7:0]                          font_byte,
    input  logic                                cfg_we,
    input  logic [btr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [btr_pkg::COLOR_W-1:0]         cfg_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [btr_pkg::COORD_W-1:0]         row_x,
    output logic [btr_pkg::COORD_W-1:0]         row_y,
    output logic [btr_pkg::MASK_W-1:0]          row_mask,
    output logic [btr_pkg::COLOR_W-1:0]         row_color,
    output logic                                last_row
);

    import btr_pkg::*;

    // Configuration
    logic [COLOR_W-1:0] pixel_color_reg;
    logic [ZOOM_W-1:0]  zoom_reg;
    logic [ZOOM_W-1:0]  eff_zoom;

    // Cursor
    logic [COORD_W-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_W-1:0] cursor_y_reg, cursor_y_next;

    // Character being drawn
    logic [7:0]         glyph_reg;
    logic [COORD_W-1:0] x_base_reg;
    logic [COORD_W-1:0] y_cnt_reg;
    logic [ZOOM_W-1:0]  z_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [ZOOM_W-1:0]  sub_reg;

    // Read stage
    logic               s1_valid_reg, s1_valid_next;
    logic [COORD_W-1:0] s1_x_reg;
    logic [COORD_W-1:0] s1_y_reg;
    logic               s1_last_reg;
    logic [7:0]         font_q;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] row_x_reg;
    logic [COORD_W-1:0] row_y_reg;
    logic [MASK_W-1:0]  row_mask_reg;
    logic [COLOR_W-1:0] row_color_reg;
    logic               last_row_reg;

    logic               advance;
    logic               is_ctrl_code;
    logic               font_we;
    logic [FONT_AW-1:0] rd_addr;
    logic               at_last;
    logic [7:0]         glyph_sel;

    // Clamp zoom to the supported range
    always_comb
    begin
        if (zoom_reg == '0)
        begin
            eff_zoom = ZOOM_W'(1);
        end
        else if (zoom_reg > ZOOM_W'(MAX_ZOOM))
        begin
            eff_zoom = ZOOM_W'(MAX_ZOOM);
        end
        else
        begin
            eff_zoom = zoom_reg;
        end
    end

    // Classify the item on the input channel
    assign is_ctrl_code = (char_code == CODE_CR) || (char_code == CODE_LF);
    assign glyph_sel    = ({1'b0, char_code} < 9'(GLYPH_COUNT)) ? char_code : 8'd0;
    assign font_we      = cmd.accept && (mode == MODE_LOAD);

    assign at_last = (row_reg == ROW_W'(GLYPH_HEIGHT - 1)) && (sub_reg == z_reg - 1'b1);
    assign advance = !out_valid_reg || !out_stall;

    always_comb
    begin
        sts.is_glyph  = (mode == MODE_PUT) && !is_ctrl_code;
        sts.last_row  = at_last;
        sts.slot_free = !s1_valid_reg || advance;
    end

    assign rd_addr = FONT_AW'(int'(glyph_reg) * GLYPH_HEIGHT + int'(row_reg));

    // Font store
    btr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font (
        .clk     (clk),
        .wr_en   (font_we),
        .wr_addr (font_address),
        .wr_data (font_byte),
        .rd_en   (cmd.issue),
        .rd_addr (rd_addr),
        .rd_data (font_q)
    );

    // Cursor update on accepted cursor-set and character items
    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        if (cmd.accept)
        begin
            priority if (mode == MODE_SET)
            begin
                cursor_x_next = new_x;
                cursor_y_next = new_y;
            end
            else if (mode == MODE_PUT && char_code == CODE_CR)
            begin
                cursor_x_next = '0;
            end
            else if (mode == MODE_PUT && char_code == CODE_LF)
            begin
                cursor_x_next = '0;
                cursor_y_next = cursor_y_reg
                              + COORD_W'(eff_zoom) * COORD_W'(GLYPH_HEIGHT);
            end
            else if (mode == MODE_PUT)
            begin
                cursor_x_next = cursor_x_reg
                              + COORD_W'(eff_zoom) * COORD_W'(GLYPH_WIDTH);
            end
            else
            begin
                cursor_x_next = cursor_x_reg;
            end
        end
    end

    // Read stage and output register occupancy
    always_comb
    begin
        if (cmd.issue)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_valid_reg && advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_color_reg <= '1;
            zoom_reg        <= ZOOM_W'(1);
            cursor_x_reg    <= '0;
            cursor_y_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            row_reg         <= '0;
            sub_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PIXEL_COLOR: pixel_color_reg <= cfg_data;
                    CFG_ZOOM:        zoom_reg        <= cfg_data[ZOOM_W-1:0];
                    default:         zoom_reg        <= zoom_reg;
                endcase
            end
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;

            // Advance the row counters: each glyph row repeats zoom times
            if (cmd.accept)
            begin
                row_reg <= '0;
                sub_reg <= '0;
            end
            else if (cmd.issue)
            begin
                if (sub_reg == z_reg - 1'b1)
                begin
                    sub_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    sub_reg <= sub_reg + 1'b1;
                end
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept && sts.is_glyph)
        begin
            glyph_reg  <= glyph_sel;
            x_base_reg <= cursor_x_reg;
            y_cnt_reg  <= cursor_y_reg + 1'b1;
            z_reg      <= eff_zoom;
        end
        else if (cmd.issue)
        begin
            y_cnt_reg <= y_cnt_reg + 1'b1;
        end

        if (cmd.issue)
        begin
            s1_x_reg    <= x_base_reg;
            s1_y_reg    <= y_cnt_reg;
            s1_last_reg <= at_last;
        end

        if (s1_valid_reg && advance)
        begin
            row_x_reg     <= s1_x_reg;
            row_y_reg     <= s1_y_reg;
            row_mask_reg  <= scale_mask(font_q, z_reg);
            row_color_reg <= pixel_color_reg;
            last_row_reg  <= s1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_x     = row_x_reg;
    assign row_y     = row_y_reg;
    assign row_mask  = row_mask_reg;
    assign row_color = row_color_reg;
    assign last_row  = last_row_reg;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |-> !cmd.issue)
        else $error("row read while read stage blocked");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance) |=> out_valid_reg)
        else $error("read stage row lost");

    a_sub_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (sub_reg < z_reg))
        else $error("zoom repeat count out of range");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && at_last) |=> (row_reg == '0 && sub_reg == '0))
        else $error("row counters did not wrap after final row");

endmodule

FILE: tb/bitmap_text_renderer_test.sv
`timescale 1ns / 100ps

module bitmap_text_renderer_test;

    import btr_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 245;

    // One transfer on the character channel
    typedef struct packed {
        logic [1:0]         mode;
        logic [7:0]         code;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [FONT_AW-1:0] addr;
        logic [7:0]         font_byte;
    } text_cmd_t;

    // One framebuffer row write
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [MASK_W-1:0]  mask;
        logic [COLOR_W-1:0] color;
        logic               last;
    } fb_row_t;

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_stall;
    logic [1:0]           mode         = MODE_PUT;
    logic [7:0]           char_code    = '0;
    logic [COORD_W-1:0]   new_x        = '0;
    logic [COORD_W-1:0]   new_y        = '0;
    logic [FONT_AW-1:0]   font_address = '0;
    logic [7:0]           font_byte    = '0;
    logic                 out_valid;
    logic                 out_stall    = 1'b0;
    logic [COORD_W-1:0]   row_x;
    logic [COORD_W-1:0]   row_y;
    logic [MASK_W-1:0]    row_mask;
    logic [COLOR_W-1:0]   row_color;
    logic                 last_row;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_PIXEL_COLOR;
    logic [COLOR_W-1:0]   cfg_data     = '0;

    // Shadow state of the renderer
    logic [COLOR_W-1:0]   color_reg = '1;
    logic [ZOOM_W-1:0]    zoom_reg  = 3'd1;
    logic [COORD_W-1:0]   cur_x     = '0;
    logic [COORD_W-1:0]   cur_y     = '0;
    logic [7:0]           font_shadow [FONT_DEPTH];
    bit                   font_seen [FONT_DEPTH];
    bit                   glyph_ready [GLYPH_COUNT];
    int                   loaded_glyphs [$];

    fb_row_t              rows_due [$];
    int                   mismatches = 0;
    int                   burst_left = 0;
    bit                   in_valid_held = 1'b0;
    int                   stall_style = 0;
    int                   style_left = 0;

    bitmap_text_renderer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .char_code    (char_code),
        .new_x        (new_x),
        .new_y        (new_y),
        .font_address (font_address),
        .font_byte    (font_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .row_x        (row_x),
        .row_y        (row_y),
        .row_mask     (row_mask),
        .row_color    (row_color),
        .last_row     (last_row),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Stretch a font byte across zoom pixels per bit
    function automatic logic [MASK_W-1:0] stretch_bits(input logic [7:0] bits, input int z);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int j = 0; j < GLYPH_WIDTH * z && j < MASK_W; j++)
            m[j] = bits[j / z];
        return m;
    endfunction

    // Advance the shadow state by one accepted transfer and queue its rows
    function automatic void plot_rows(input text_cmd_t c);
        int                 z;
        int                 rows;
        int                 glyph;
        bit                 full;
        logic [FONT_AW-1:0] a;
        fb_row_t            r;
        z = (zoom_reg == 0) ? 1 : (zoom_reg > MAX_ZOOM) ? MAX_ZOOM : int'(zoom_reg);
        rows = GLYPH_HEIGHT * z;
        case (c.mode)
            MODE_SET:
            begin
                cur_x = c.x;
                cur_y = c.y;
            end
            MODE_LOAD:
            begin
                font_shadow[c.addr] = c.font_byte;
                font_seen[c.addr] = 1'b1;
                glyph = c.addr / GLYPH_HEIGHT;
                if (glyph < GLYPH_COUNT && !glyph_ready[glyph])
                begin
                    full = 1'b1;
                    for (int k = 0; k < GLYPH_HEIGHT; k++)
                        full &= font_seen[glyph * GLYPH_HEIGHT + k];
                    if (full)
                    begin
                        glyph_ready[glyph] = 1'b1;
                        loaded_glyphs.push_back(glyph);
                    end
                end
            end
            MODE_PUT:
            begin
                if (c.code == CODE_CR)
                    cur_x = '0;
                else if (c.code == CODE_LF)
                begin
                    cur_x = '0;
                    cur_y = cur_y + COORD_W'(rows);
                end
                else
                begin
                    glyph = (int'(c.code) < GLYPH_COUNT) ? int'(c.code) : 0;
                    for (int k = 0; k < rows; k++)
                    begin
                        a = FONT_AW'(glyph * GLYPH_HEIGHT + k / z);
                        r.x = cur_x;
                        r.y = cur_y + COORD_W'(k + 1);
                        r.mask = stretch_bits(font_shadow[a], z);
                        r.color = color_reg;
                        r.last = (k == rows - 1);
                        rows_due.push_back(r);
                    end
                    cur_x = cur_x + COORD_W'(GLYPH_WIDTH * z);
                end
            end
            default:
            begin
                // undefined mode: nothing changes
            end
        endcase
    endfunction

    function automatic text_cmd_t rand_cmd();
        text_cmd_t c;
        c.mode = 2'($urandom_range(0, 3));
        c.code = 8'($urandom);
        c.x = COORD_W'($urandom);
        c.y = COORD_W'($urandom);
        c.addr = FONT_AW'($urandom);
        c.font_byte = 8'($urandom);
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Drop valid if it is still held from the last transfer
    task automatic idle_input();
        if (in_valid_held)
        begin
            in_valid <= 1'b0;
            in_valid_held = 1'b0;
        end
    endtask

    // Offer one transfer, hold it until taken, then maybe pause between bursts
    task automatic send_cmd(input text_cmd_t c);
        int gap;
        in_valid     <= 1'b1;
        mode         <= c.mode;
        char_code    <= c.code;
        new_x        <= c.x;
        new_y        <= c.y;
        font_address <= c.addr;
        font_byte    <= c.font_byte;
        in_valid_held = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        plot_rows(c);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                idle_input();
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Hold the sender until every queued row has come out
    task automatic wait_drained();
        idle_input();
        @(posedge clk);
        while (rows_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [COLOR_W-1:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_PIXEL_COLOR)
            color_reg = data;
        else
            zoom_reg = data[ZOOM_W-1:0];
    endtask

    task automatic put_char(input logic [7:0] code);
        text_cmd_t c;
        c = rand_cmd();
        c.mode = MODE_PUT;
        c.code = code;
        send_cmd(c);
    endtask

    task automatic set_cursor(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        text_cmd_t c;
        c = rand_cmd();
        c.mode = MODE_SET;
        c.x = x;
        c.y = y;
        send_cmd(c);
    endtask

    task automatic load_glyph(input int glyph);
        text_cmd_t c;
        for (int k = 0; k < GLYPH_HEIGHT; k++)
        begin
            c = rand_cmd();
            c.mode = MODE_LOAD;
            c.addr = FONT_AW'(glyph * GLYPH_HEIGHT + k);
            case ($urandom_range(0, 5))
                0: c.font_byte = 8'h00;
                1: c.font_byte = 8'hFF;
                default: ;
            endcase
            send_cmd(c);
        end
    endtask

    // Load the top glyph with edge patterns in its rows
    task automatic test_font_load();
        text_cmd_t c;
        logic [7:0] pattern [GLYPH_HEIGHT];
        pattern = '{8'hFF, 8'h00, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h0F, 8'hF0,
                    8'h81, 8'h7E, 8'h18, 8'hC3, 8'h3C, 8'h24, 8'h42, 8'hFF};
        for (int k = 0; k < GLYPH_HEIGHT; k++)
        begin
            c = rand_cmd();
            c.mode = MODE_LOAD;
            c.addr = FONT_AW'((GLYPH_COUNT - 1) * GLYPH_HEIGHT + k);
            c.font_byte = pattern[k];
            send_cmd(c);
        end
    endtask

    // Default settings: plain render, cursor wrap, CR, LF, undefined mode
    task automatic test_controls_and_wrap();
        text_cmd_t c;
        put_char(8'hFF);
        set_cursor(16'hFFFC, 16'hFFF8);
        put_char(8'hFF);
        put_char(CODE_CR);
        put_char(8'hFF);
        put_char(CODE_LF);
        put_char(8'hFF);
        c = rand_cmd();
        c.mode = 2'd3;
        send_cmd(c);
        put_char(8'hFF);
        set_cursor(16'h0000, 16'hFFFF);
        put_char(CODE_LF);
    endtask

    // Zoom at and beyond its limits, colour at its extremes
    task automatic test_zoom_extremes();
        logic [ZOOM_W-1:0] zooms [4];
        zooms = '{3'd0, 3'd4, 3'd7, 3'd3};
        for (int i = 0; i < 4; i++)
        begin
            write_setting(CFG_ZOOM, {29'($urandom), zooms[i]});
            write_setting(CFG_PIXEL_COLOR, (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF
                                                                        : 32'($urandom));
            set_cursor(COORD_W'($urandom), 16'hFFF0);
            put_char(8'hFF);
        end
    endtask

    // Mostly text runs over loaded glyphs, with font loads, cursor moves and noise
    task automatic test_random_text();
        text_cmd_t c;
        int counted;
        int pick;
        int n;
        int r;
        counted = 0;
        load_glyph(0);
        counted += GLYPH_HEIGHT;
        repeat (3)
        begin
            load_glyph($urandom_range(0, GLYPH_COUNT - 1));
            counted += GLYPH_HEIGHT;
        end
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                load_glyph($urandom_range(0, GLYPH_COUNT - 1));
                counted += GLYPH_HEIGHT;
            end
            else if (pick < 62)
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        put_char(CODE_CR);
                    else if (r == 1)
                        put_char(CODE_LF);
                    else
                        put_char(8'(loaded_glyphs[$urandom_range(0, loaded_glyphs.size() - 1)]));
                    counted++;
                end
            end
            else if (pick < 72)
            begin
                if ($urandom_range(0, 3) == 0)
                    set_cursor(16'hFFF0 + COORD_W'($urandom_range(0, 15)),
                               16'hFFC0 + COORD_W'($urandom_range(0, 63)));
                else
                    set_cursor(COORD_W'($urandom), COORD_W'($urandom));
                counted++;
            end
            else if (pick < 80)
            begin
                c = rand_cmd();
                c.mode = MODE_LOAD;
                send_cmd(c);
                counted++;
            end
            else if (pick < 86)
            begin
                c = rand_cmd();
                c.mode = 2'd3;
                send_cmd(c);
                counted++;
            end
            else if ($urandom_range(0, 1) == 0)
                write_setting(CFG_ZOOM, 32'($urandom));
            else
            begin
                case ($urandom_range(0, 2))
                    0: write_setting(CFG_PIXEL_COLOR, 32'h0);
                    1: write_setting(CFG_PIXEL_COLOR, 32'hFFFF_FFFF);
                    default: write_setting(CFG_PIXEL_COLOR, 32'($urandom));
                endcase
            end
        end
    endtask

    // Receiver stall pattern: quiet, light or heavy stretches
    always @(posedge clk)
    begin
        if (style_left == 0)
        begin
            stall_style = $urandom_range(0, 2);
            style_left = $urandom_range(8, 80);
        end
        else
            style_left--;
        case (stall_style)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Check each row transfer against the oldest queued row
    always @(posedge clk)
    begin
        fb_row_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (rows_due.size() == 0)
                report_mismatch("unexpected row, row_y", 32'(row_y), '0);
            else
            begin
                want = rows_due.pop_front();
                if (row_x !== want.x)
                    report_mismatch("row_x", 32'(row_x), 32'(want.x));
                if (row_y !== want.y)
                    report_mismatch("row_y", 32'(row_y), 32'(want.y));
                if (row_mask !== want.mask)
                    report_mismatch("row_mask", row_mask, want.mask);
                if (row_color !== want.color)
                    report_mismatch("row_color", row_color, want.color);
                if (last_row !== want.last)
                    report_mismatch("last_row", 32'(last_row), 32'(want.last));
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_font_load();
        test_controls_and_wrap();
        test_zoom_extremes();
        test_random_text();
        wait_drained();
        if (mismatches == 0 && rows_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
